// ----- design/qed_pkg.sv -----
// Shared types, codes and constants of the quadrature encoder decoder.
package qed_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TIME_WIDTH_DEFAULT  = 32;

   localparam int POS_WIDTH      = 31;
   localparam int KIND_WIDTH     = 2;
   localparam int DIR_WIDTH      = 2;
   localparam int MODE_WIDTH     = 2;
   localparam int GAP_WIDTH      = 8;
   localparam int CPR_WIDTH      = 11;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 11;
   localparam int PORT_TIME_WIDTH = 32;
   localparam int RPM_WIDTH      = 16;

   // Divider: 60000 over a product of a 16-bit time and an 11-bit count.
   localparam int DIVIDEND_WIDTH  = 16;
   localparam int PRODUCT_WIDTH   = DIVIDEND_WIDTH + CPR_WIDTH;
   localparam int DIV_CNT_WIDTH   = $clog2(DIVIDEND_WIDTH);
   localparam logic [DIVIDEND_WIDTH-1:0] RPM_NUMERATOR = 16'd60000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LATCH_MODE     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_SAMPLE_GAP = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COUNTS_PER_REV = 2'd2;

   localparam logic [MODE_WIDTH-1:0] LATCH_MODE_RESET  = 2'd0;
   localparam logic [GAP_WIDTH-1:0]  MIN_GAP_RESET     = 8'd3;
   localparam logic [CPR_WIDTH-1:0]  COUNTS_PER_REV_RESET = 11'd20;

   // Latch modes.
   localparam logic [MODE_WIDTH-1:0] LATCH_ON_3    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] LATCH_ON_0    = 2'd1;
   localparam logic [MODE_WIDTH-1:0] LATCH_ON_BOTH = 2'd2;

   // Request kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_POLL   = 2'd2;

   // Direction codes.
   localparam logic [DIR_WIDTH-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_WIDTH-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_WIDTH-1:0] DIR_CCW  = 2'd2;

   // Pin states where a detent position may be published.
   localparam logic [1:0] PINS_LOW  = 2'd0;
   localparam logic [1:0] PINS_HIGH = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } fsm_state_type;

   // Step of the fine count for a transition {previous pins, new pins}.
   function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

// ----- design/qed_div.sv -----
// Restoring divider that works out 60000 / divisor, one quotient bit a cycle.
module qed_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [qed_pkg::PRODUCT_WIDTH-1:0]      divisor,
   output logic                                   done,
   output logic [qed_pkg::DIVIDEND_WIDTH-1:0]     quotient
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [qed_pkg::DIV_CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [qed_pkg::DIVIDEND_WIDTH-1:0]     rem_ff, rem_in;
   logic [qed_pkg::DIVIDEND_WIDTH-1:0]     quo_ff, quo_in;
   logic [qed_pkg::PRODUCT_WIDTH-1:0]      div_ff, div_in;
   logic [qed_pkg::DIVIDEND_WIDTH:0]       trial;
   logic [qed_pkg::PRODUCT_WIDTH-1:0]      diff;
   logic                                   fits;

   // The remainder never exceeds the dividend bits taken so far, so it fits 16 bits.
   assign trial = {rem_ff, quo_ff[qed_pkg::DIVIDEND_WIDTH-1]};
   assign fits  = qed_pkg::PRODUCT_WIDTH'(trial) >= div_ff;
   assign diff  = qed_pkg::PRODUCT_WIDTH'(trial) - div_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = qed_pkg::RPM_NUMERATOR;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[qed_pkg::DIVIDEND_WIDTH-1:0]
                       : trial[qed_pkg::DIVIDEND_WIDTH-1:0];
         quo_in = {quo_ff[qed_pkg::DIVIDEND_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == qed_pkg::DIV_CNT_WIDTH'(qed_pkg::DIVIDEND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/quadrature_encoder_decoder.sv -----
// Top level of the quadrature encoder decoder: pin decoding, position state and rpm sequencer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | kind, pin_a, pin_b, now_ms, new_position
//   rsp     | out       | rsp_valid/rsp_stall | position, direction, interval_ms, rpm
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// Non-poll requests go from acceptance to ST_OUT, which loads the result register once it is free.
// A poll goes through ST_MUL for the product, ST_DIV for the 16 divider steps, which ends by
// taking the quotient, and then ST_OUT to load the result; ST_DIV is skipped if rpm saturates or is zero.
// One request is worked on at a time; req_stall is high from acceptance until the result is
// written into the output register, which may still hold an earlier result waiting on rsp_stall.
// Reset is synchronous and returns the position state and the latch and sample times to zero and the
// registers to their reset values; req_stall is held high while reset is asserted.
module quadrature_encoder_decoder #(
   parameter int COUNT_WIDTH = qed_pkg::COUNT_WIDTH_DEFAULT,
   parameter int TIME_WIDTH  = qed_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [qed_pkg::KIND_WIDTH-1:0]           req_kind,
   input  logic                                     req_pin_a,
   input  logic                                     req_pin_b,
   input  logic [qed_pkg::PORT_TIME_WIDTH-1:0]      req_now_ms,
   input  logic signed [qed_pkg::POS_WIDTH-1:0]     req_new_position,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [qed_pkg::POS_WIDTH-1:0]     rsp_position,
   output logic [qed_pkg::DIR_WIDTH-1:0]            rsp_direction,
   output logic [qed_pkg::PORT_TIME_WIDTH-1:0]      rsp_interval_ms,
   output logic [qed_pkg::RPM_WIDTH-1:0]            rsp_rpm,
   input  logic                                     csr_we,
   input  logic [qed_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [qed_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);

   localparam int EXT_WIDTH = (COUNT_WIDTH > qed_pkg::POS_WIDTH + 2) ?
                              COUNT_WIDTH : qed_pkg::POS_WIDTH + 2;

   qed_pkg::fsm_state_type state_ff, state_in;

   logic [qed_pkg::MODE_WIDTH-1:0]  latch_mode_ff, latch_mode_in;
   logic [qed_pkg::GAP_WIDTH-1:0]   min_gap_ff, min_gap_in;
   logic [qed_pkg::CPR_WIDTH-1:0]   cpr_ff, cpr_in;

   logic [COUNT_WIDTH-1:0]                 fine_ff, fine_in;
   logic [1:0]                             last_pins_ff, last_pins_in;
   logic signed [qed_pkg::POS_WIDTH-1:0]   detent_ff, detent_in;
   logic signed [qed_pkg::POS_WIDTH-1:0]   polled_ff, polled_in;
   logic [TIME_WIDTH-1:0]                  latch_time_ff, latch_time_in;
   logic [TIME_WIDTH-1:0]                  prev_latch_ff, prev_latch_in;
   logic [TIME_WIDTH-1:0]                  last_sample_ff, last_sample_in;

   logic [TIME_WIDTH-1:0]                  t_ff, t_in;
   logic [qed_pkg::DIR_WIDTH-1:0]          dir_ff, dir_in;
   logic [qed_pkg::RPM_WIDTH-1:0]          rpm_ff, rpm_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [qed_pkg::POS_WIDTH-1:0]   rsp_position_ff, rsp_position_in;
   logic [qed_pkg::DIR_WIDTH-1:0]          rsp_direction_ff, rsp_direction_in;
   logic [qed_pkg::PORT_TIME_WIDTH-1:0]    rsp_interval_ff, rsp_interval_in;
   logic [qed_pkg::RPM_WIDTH-1:0]          rsp_rpm_ff, rsp_rpm_in;

   logic                                   accept;
   logic                                   out_load;
   logic                                   div_start;
   logic                                   div_done;
   logic [qed_pkg::DIVIDEND_WIDTH-1:0]     div_quotient;
   logic [qed_pkg::PRODUCT_WIDTH-1:0]      div_divisor;
   logic                                   rpm_saturate;
   logic                                   rpm_zero;

   logic [TIME_WIDTH-1:0]                  now_t;
   logic [TIME_WIDTH-1:0]                  gap;
   logic [TIME_WIDTH-1:0]                  t_latch;
   logic [TIME_WIDTH-1:0]                  t_since;
   logic [1:0]                             pins;
   logic [COUNT_WIDTH-1:0]                 fine_stepped;
   logic signed [EXT_WIDTH-1:0]            fine_ext;
   logic signed [EXT_WIDTH-1:0]            load_ext;
   logic signed [EXT_WIDTH-1:0]            load_x4;
   logic signed [EXT_WIDTH-1:0]            load_x2;
   logic                                   publish;
   logic                                   half_step;

   // ---------------- datapath helpers ----------------
   assign now_t   = TIME_WIDTH'(req_now_ms);
   assign gap     = now_t - last_sample_ff;
   assign t_latch = latch_time_ff - prev_latch_ff;
   assign t_since = now_t - latch_time_ff;
   assign pins    = {req_pin_b, req_pin_a};

   assign fine_stepped = fine_ff +
      COUNT_WIDTH'(qed_pkg::step_delta({last_pins_ff, pins}));
   assign fine_ext = EXT_WIDTH'($signed(fine_stepped));
   assign load_ext = EXT_WIDTH'(req_new_position);
   assign load_x4  = load_ext <<< 2;
   assign load_x2  = load_ext <<< 1;

   always_comb begin
      publish   = 1'b0;
      half_step = 1'b0;
      case (latch_mode_ff)
         qed_pkg::LATCH_ON_3: publish = (pins == qed_pkg::PINS_HIGH);
         qed_pkg::LATCH_ON_0: publish = (pins == qed_pkg::PINS_LOW);
         qed_pkg::LATCH_ON_BOTH: begin
            publish   = (pins == qed_pkg::PINS_LOW) || (pins == qed_pkg::PINS_HIGH);
            half_step = 1'b1;
         end
         default: publish = 1'b0;
      endcase
   end

   // ---------------- position and time state ----------------
   always_comb begin
      fine_in        = fine_ff;
      last_pins_in   = last_pins_ff;
      detent_in      = detent_ff;
      polled_in      = polled_ff;
      latch_time_in  = latch_time_ff;
      prev_latch_in  = prev_latch_ff;
      last_sample_in = last_sample_ff;
      t_in           = t_ff;
      dir_in         = dir_ff;
      if (accept) begin
         dir_in = qed_pkg::DIR_NONE;
         case (req_kind)
            qed_pkg::KIND_SAMPLE: begin
               if (gap >= TIME_WIDTH'(min_gap_ff)) begin
                  last_sample_in = now_t;
                  if (pins != last_pins_ff) begin
                     fine_in      = fine_stepped;
                     last_pins_in = pins;
                     if (publish) begin
                        detent_in     = half_step ? qed_pkg::POS_WIDTH'(fine_ext >>> 1)
                                                  : qed_pkg::POS_WIDTH'(fine_ext >>> 2);
                        prev_latch_in = latch_time_ff;
                        latch_time_in = now_t;
                     end
                  end
               end
            end
            qed_pkg::KIND_LOAD: begin
               if ((latch_mode_ff == qed_pkg::LATCH_ON_3) ||
                   (latch_mode_ff == qed_pkg::LATCH_ON_0)) begin
                  fine_in   = {load_x4[COUNT_WIDTH-1:2], fine_ff[1:0]};
                  detent_in = req_new_position;
                  polled_in = req_new_position;
               end else if (latch_mode_ff == qed_pkg::LATCH_ON_BOTH) begin
                  fine_in   = {load_x2[COUNT_WIDTH-1:1], fine_ff[0]};
                  detent_in = req_new_position;
                  polled_in = req_new_position;
               end
            end
            qed_pkg::KIND_POLL: begin
               polled_in = detent_ff;
               if (polled_ff > detent_ff) begin
                  dir_in = qed_pkg::DIR_CCW;
               end else if (polled_ff < detent_ff) begin
                  dir_in = qed_pkg::DIR_CW;
               end
               t_in = (t_latch > t_since) ? t_latch : t_since;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- configuration ----------------
   always_comb begin
      latch_mode_in = latch_mode_ff;
      min_gap_in    = min_gap_ff;
      cpr_in        = cpr_ff;
      if (csr_we) begin
         case (csr_index)
            qed_pkg::CSR_LATCH_MODE:     latch_mode_in = qed_pkg::MODE_WIDTH'(csr_wdata);
            qed_pkg::CSR_MIN_SAMPLE_GAP: min_gap_in    = qed_pkg::GAP_WIDTH'(csr_wdata);
            qed_pkg::CSR_COUNTS_PER_REV: cpr_in        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------- rpm sequencer ----------------
   assign rpm_saturate = (t_ff == '0) || (cpr_ff == '0);
   assign rpm_zero     = t_ff > TIME_WIDTH'(qed_pkg::RPM_NUMERATOR);
   assign div_divisor  = qed_pkg::PRODUCT_WIDTH'(t_ff[qed_pkg::DIVIDEND_WIDTH-1:0]) *
                         qed_pkg::PRODUCT_WIDTH'(cpr_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qed_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == qed_pkg::KIND_POLL) ? qed_pkg::ST_MUL
                                                           : qed_pkg::ST_OUT;
            end
         end
         qed_pkg::ST_MUL: begin
            state_in = (rpm_saturate || rpm_zero) ? qed_pkg::ST_OUT : qed_pkg::ST_DIV;
         end
         qed_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = qed_pkg::ST_OUT;
            end
         end
         qed_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = qed_pkg::ST_IDLE;
            end
         end
         default: state_in = qed_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = reset || (state_ff != qed_pkg::ST_IDLE);
      accept    = req_valid && !req_stall;
      div_start = (state_ff == qed_pkg::ST_MUL) && !rpm_saturate && !rpm_zero;
      out_load  = (state_ff == qed_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      rpm_in = rpm_ff;
      if (accept) begin
         rpm_in = '0;
      end else if (state_ff == qed_pkg::ST_MUL) begin
         if (rpm_saturate) begin
            rpm_in = qed_pkg::RPM_NUMERATOR;
         end else if (rpm_zero) begin
            rpm_in = '0;
         end
      end else if ((state_ff == qed_pkg::ST_DIV) && div_done) begin
         rpm_in = div_quotient;
      end
   end

   qed_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_position_in  = rsp_position_ff;
      rsp_direction_in = rsp_direction_ff;
      rsp_interval_in  = rsp_interval_ff;
      rsp_rpm_in       = rsp_rpm_ff;
      if (out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_position_in  = detent_ff;
         rsp_direction_in = dir_ff;
         rsp_interval_in  = qed_pkg::PORT_TIME_WIDTH'(t_latch);
         rsp_rpm_in       = rpm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= qed_pkg::ST_IDLE;
         latch_mode_ff  <= qed_pkg::LATCH_MODE_RESET;
         min_gap_ff     <= qed_pkg::MIN_GAP_RESET;
         cpr_ff         <= qed_pkg::COUNTS_PER_REV_RESET;
         fine_ff        <= '0;
         last_pins_ff   <= '0;
         detent_ff      <= '0;
         polled_ff      <= '0;
         latch_time_ff  <= '0;
         prev_latch_ff  <= '0;
         last_sample_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         latch_mode_ff  <= latch_mode_in;
         min_gap_ff     <= min_gap_in;
         cpr_ff         <= cpr_in;
         fine_ff        <= fine_in;
         last_pins_ff   <= last_pins_in;
         detent_ff      <= detent_in;
         polled_ff      <= polled_in;
         latch_time_ff  <= latch_time_in;
         prev_latch_ff  <= prev_latch_in;
         last_sample_ff <= last_sample_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      t_ff             <= t_in;
      dir_ff           <= dir_in;
      rpm_ff           <= rpm_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_interval_ff  <= rsp_interval_in;
      rsp_rpm_ff       <= rsp_rpm_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_direction   = rsp_direction_ff;
   assign rsp_interval_ms = rsp_interval_ff;
   assign rsp_rpm         = rsp_rpm_ff;

endmodule

// ----- design/qed_checker.sv -----
// Port-level checks of the quadrature encoder decoder, bound to the top level.
module qed_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [qed_pkg::POS_WIDTH-1:0]  rsp_position,
   input logic [qed_pkg::DIR_WIDTH-1:0]         rsp_direction,
   input logic [qed_pkg::RPM_WIDTH-1:0]         rsp_rpm
);

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in work");

   a_rpm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rpm <= qed_pkg::RPM_NUMERATOR))
      else $error("rpm above its saturation value");

   // The direction of a valid result is always one of the three defined codes.
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction == qed_pkg::DIR_NONE) ||
                    (rsp_direction == qed_pkg::DIR_CW) ||
                    (rsp_direction == qed_pkg::DIR_CCW))
      else $error("direction code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position) && $stable(rsp_rpm)))
      else $error("stalled result changed");

endmodule

bind quadrature_encoder_decoder qed_checker u_qed_checker (.*);

// ----- tb/quadrature_encoder_decoder_tb.sv -----
// Self-checking testbench of the quadrature encoder decoder against a behavioral predictor.
module quadrature_encoder_decoder_tb;

   localparam logic [qed_pkg::KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;
   localparam logic [qed_pkg::MODE_WIDTH-1:0] LATCH_NEVER = 2'd3;
   localparam int QUIET_LIMIT = 2000;

   // Fine count step for each {previous pins, new pins} transition.
   localparam int STEP_OF [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
   // Pin states one step up and one step down the Gray sequence.
   localparam logic [1:0] NEXT_UP [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] NEXT_DOWN [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   typedef struct {
      logic [qed_pkg::KIND_WIDTH-1:0]      kind;
      logic                                pin_a;
      logic                                pin_b;
      logic [qed_pkg::PORT_TIME_WIDTH-1:0] now_ms;
      logic signed [qed_pkg::POS_WIDTH-1:0] new_position;
   } encoder_request_type;

   typedef struct {
      logic signed [qed_pkg::POS_WIDTH-1:0] position;
      logic [qed_pkg::DIR_WIDTH-1:0]        direction;
      logic [qed_pkg::PORT_TIME_WIDTH-1:0]  interval_ms;
      logic [qed_pkg::RPM_WIDTH-1:0]        rpm;
   } encoder_result_type;

   logic                                        clock;
   logic                                        reset;
   logic                                        req_valid;
   logic                                        req_stall;
   logic [qed_pkg::KIND_WIDTH-1:0]              req_kind;
   logic                                        req_pin_a;
   logic                                        req_pin_b;
   logic [qed_pkg::PORT_TIME_WIDTH-1:0]         req_now_ms;
   logic signed [qed_pkg::POS_WIDTH-1:0]        req_new_position;
   logic                                        rsp_valid;
   logic                                        rsp_stall;
   logic signed [qed_pkg::POS_WIDTH-1:0]        rsp_position;
   logic [qed_pkg::DIR_WIDTH-1:0]               rsp_direction;
   logic [qed_pkg::PORT_TIME_WIDTH-1:0]         rsp_interval_ms;
   logic [qed_pkg::RPM_WIDTH-1:0]               rsp_rpm;
   logic                                        csr_we;
   logic [qed_pkg::CSR_IDX_WIDTH-1:0]           csr_index;
   logic [qed_pkg::CSR_DATA_WIDTH-1:0]          csr_wdata;

   // Predictor copy of the registers and the decoder state.
   logic [qed_pkg::MODE_WIDTH-1:0]       cfg_mode = qed_pkg::LATCH_MODE_RESET;
   logic [qed_pkg::GAP_WIDTH-1:0]        cfg_gap = qed_pkg::MIN_GAP_RESET;
   logic [qed_pkg::CPR_WIDTH-1:0]        cfg_cpr = qed_pkg::COUNTS_PER_REV_RESET;
   logic [31:0]                          fine_steps = '0;
   logic [1:0]                           pin_state = '0;
   logic signed [qed_pkg::POS_WIDTH-1:0] detent_pos = '0;
   logic signed [qed_pkg::POS_WIDTH-1:0] polled_pos = '0;
   logic [31:0]                          stamp_time = '0;
   logic [31:0]                          prev_stamp_time = '0;
   logic [31:0]                          sample_time = '0;

   encoder_result_type pending_results[$];
   int                 mismatches = 0;
   int                 hold_rsp_cycles = 0;
   bit                 idle_on = 1'b1;
   logic [31:0]        clk_ms = '0;
   logic [1:0]         pins_now = '0;

   quadrature_encoder_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pin_a        (req_pin_a),
      .req_pin_b        (req_pin_b),
      .req_now_ms       (req_now_ms),
      .req_new_position (req_new_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_direction    (rsp_direction),
      .rsp_interval_ms  (rsp_interval_ms),
      .rsp_rpm          (rsp_rpm),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void publish_detent(int shift, logic [31:0] now);
      detent_pos = qed_pkg::POS_WIDTH'($signed(fine_steps) >>> shift);
      prev_stamp_time = stamp_time;
      stamp_time = now;
   endfunction

   // Applies one request to the predicted state and returns the result it must produce.
   function automatic encoder_result_type decode_request(encoder_request_type rq);
      encoder_result_type rs;
      logic [1:0]         pins;
      logic [31:0]        since_sample;
      logic [31:0]        stamp_gap;
      logic [31:0]        since_stamp;
      logic [31:0]        t_use;
      longint unsigned    divisor;
      rs.direction = qed_pkg::DIR_NONE;
      rs.rpm = '0;
      if (rq.kind == qed_pkg::KIND_SAMPLE) begin
         since_sample = rq.now_ms - sample_time;
         if (since_sample >= 32'(cfg_gap)) begin
            pins = {rq.pin_b, rq.pin_a};
            sample_time = rq.now_ms;
            if (pins != pin_state) begin
               fine_steps = fine_steps + 32'(STEP_OF[{pin_state, pins}]);
               pin_state = pins;
               if ((cfg_mode == qed_pkg::LATCH_ON_3 && pins == qed_pkg::PINS_HIGH) ||
                   (cfg_mode == qed_pkg::LATCH_ON_0 && pins == qed_pkg::PINS_LOW)) begin
                  publish_detent(2, rq.now_ms);
               end else if (cfg_mode == qed_pkg::LATCH_ON_BOTH &&
                            (pins == qed_pkg::PINS_LOW || pins == qed_pkg::PINS_HIGH)) begin
                  publish_detent(1, rq.now_ms);
               end
            end
         end
      end else if (rq.kind == qed_pkg::KIND_LOAD) begin
         if (cfg_mode == qed_pkg::LATCH_ON_3 || cfg_mode == qed_pkg::LATCH_ON_0) begin
            fine_steps = {rq.new_position[qed_pkg::POS_WIDTH-2:0], fine_steps[1:0]};
            detent_pos = rq.new_position;
            polled_pos = rq.new_position;
         end else if (cfg_mode == qed_pkg::LATCH_ON_BOTH) begin
            fine_steps = {rq.new_position, fine_steps[0]};
            detent_pos = rq.new_position;
            polled_pos = rq.new_position;
         end
      end else if (rq.kind == qed_pkg::KIND_POLL) begin
         if (polled_pos > detent_pos) begin
            rs.direction = qed_pkg::DIR_CCW;
         end else if (polled_pos < detent_pos) begin
            rs.direction = qed_pkg::DIR_CW;
         end
         polled_pos = detent_pos;
         stamp_gap = stamp_time - prev_stamp_time;
         since_stamp = rq.now_ms - stamp_time;
         t_use = (stamp_gap > since_stamp) ? stamp_gap : since_stamp;
         if (t_use == 0 || cfg_cpr == 0) begin
            rs.rpm = qed_pkg::RPM_NUMERATOR;
         end else if (t_use > 32'(qed_pkg::RPM_NUMERATOR)) begin
            rs.rpm = '0;
         end else begin
            divisor = longint'(t_use) * longint'(cfg_cpr);
            rs.rpm = qed_pkg::RPM_WIDTH'(64'(qed_pkg::RPM_NUMERATOR) / divisor);
         end
      end
      rs.position = detent_pos;
      rs.interval_ms = stamp_time - prev_stamp_time;
      return rs;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch at %0t: %s, expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // Offers one request and holds it until the block takes it.
   task automatic send_request(logic [qed_pkg::KIND_WIDTH-1:0] kind, logic a, logic b,
                               logic [31:0] now, logic signed [qed_pkg::POS_WIDTH-1:0] pos);
      encoder_request_type rq;
      rq.kind = kind;
      rq.pin_a = a;
      rq.pin_b = b;
      rq.now_ms = now;
      rq.new_position = pos;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= rq.kind;
      req_pin_a <= rq.pin_a;
      req_pin_b <= rq.pin_b;
      req_now_ms <= rq.now_ms;
      req_new_position <= rq.new_position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(decode_request(rq));
   endtask

   task automatic send_sample(logic [1:0] pins, logic [31:0] now);
      send_request(qed_pkg::KIND_SAMPLE, pins[0], pins[1], now,
                   qed_pkg::POS_WIDTH'($urandom));
   endtask

   task automatic send_poll(logic [31:0] now);
      send_request(qed_pkg::KIND_POLL, 1'($urandom), 1'($urandom), now,
                   qed_pkg::POS_WIDTH'($urandom));
   endtask

   task automatic send_load(logic signed [qed_pkg::POS_WIDTH-1:0] pos);
      send_request(qed_pkg::KIND_LOAD, 1'($urandom), 1'($urandom), $urandom, pos);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Registers change only once every pending result has come back.
   task automatic apply_settings(logic [qed_pkg::MODE_WIDTH-1:0] mode,
                                 logic [qed_pkg::GAP_WIDTH-1:0] gap,
                                 logic [qed_pkg::CPR_WIDTH-1:0] cpr);
      drain_requests();
      csr_we <= 1'b1;
      csr_index <= qed_pkg::CSR_LATCH_MODE;
      csr_wdata <= qed_pkg::CSR_DATA_WIDTH'(mode);
      @(posedge clock);
      cfg_mode = mode;
      csr_index <= qed_pkg::CSR_MIN_SAMPLE_GAP;
      csr_wdata <= qed_pkg::CSR_DATA_WIDTH'(gap);
      @(posedge clock);
      cfg_gap = gap;
      csr_index <= qed_pkg::CSR_COUNTS_PER_REV;
      csr_wdata <= cpr;
      @(posedge clock);
      cfg_cpr = cpr;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_poll(32'd0);
      send_sample(2'd2, 32'd0);
      send_sample(2'd2, 32'd2);
      send_sample(2'd2, 32'd3);
      send_sample(2'd3, 32'd6);
      send_sample(2'd3, 32'd9);
      send_sample(2'd1, 32'd12);
      send_sample(2'd0, 32'd15);
      send_sample(2'd2, 32'd18);
      send_sample(2'd3, 32'd21);
      send_poll(32'd21);
      send_load(31'sh3FFF_FFFF);
      send_poll(32'd22);
      send_load(31'sh4000_0000);
      send_request(KIND_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 31'sh7FFF_FFFF);
      send_sample(2'd1, 32'hFFFF_FFFF);
      send_sample(2'd0, 32'd2);
      // A jump across both pins moves nothing but still lands on a latch state.
      send_sample(2'd3, 32'd5);
      send_poll(32'hFFFF_FFF0);
      send_sample(2'd2, 32'd8);
      send_sample(2'd0, 32'd11);
      send_sample(2'd1, 32'd14);
      send_sample(2'd3, 32'd17);
      send_poll(32'd17);
   endtask

   task automatic test_register_corners();
      apply_settings(LATCH_NEVER, 8'd0, 11'd0);
      send_sample(2'd1, 32'd40);
      send_sample(2'd3, 32'd40);
      send_load(31'sd5);
      send_poll(32'd40);
      send_sample(2'd2, 32'd41);
      apply_settings(qed_pkg::LATCH_ON_BOTH, 8'd255, 11'd1);
      send_sample(2'd3, 32'd141);
      send_sample(2'd3, 32'd296);
      send_poll(32'd300);
   endtask

   task automatic test_random_rotation(int count);
      int roll;
      int run_left;
      bit go_up;
      run_left = 0;
      go_up = 1'b1;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            if (run_left == 0) begin
               go_up = 1'($urandom_range(0, 1));
               run_left = $urandom_range(1, 16);
            end
            run_left--;
            if (cfg_gap != 0 && $urandom_range(0, 9) == 0) begin
               send_sample(2'($urandom), clk_ms + $urandom_range(0, cfg_gap - 1));
            end else begin
               clk_ms += 32'(cfg_gap) + $urandom_range(0, 3);
               roll = $urandom_range(0, 19);
               if (roll == 0) begin
                  pins_now = ~pins_now;
               end else if (roll > 2) begin
                  pins_now = go_up ? NEXT_UP[pins_now] : NEXT_DOWN[pins_now];
               end
               send_sample(pins_now, clk_ms);
            end
         end else if (roll < 82) begin
            clk_ms += $urandom_range(0, 6);
            send_poll(clk_ms);
         end else if (roll < 88) begin
            if ($urandom_range(0, 1) == 0) begin
               send_load(qed_pkg::POS_WIDTH'($urandom));
            end else begin
               send_load(qed_pkg::POS_WIDTH'(int'($urandom_range(0, 64)) - 32));
            end
         end else if (roll < 91) begin
            send_request(KIND_UNUSED, 1'($urandom), 1'($urandom), $urandom,
                         qed_pkg::POS_WIDTH'($urandom));
         end else if (roll < 96) begin
            send_sample(2'($urandom), $urandom);
         end else begin
            clk_ms = $urandom;
            send_sample(pins_now, clk_ms);
         end
      end
   endtask

   task automatic test_receiver_holdoff();
      // The receiver stops long enough for the block to back up into its request side.
      hold_rsp_cycles = 300;
      idle_on = 1'b0;
      test_random_rotation(25);
      idle_on = 1'b1;
   endtask

   initial begin : result_receiver
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (burst == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 19);
         end
         if (hold_rsp_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_rsp_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : result_checker
      encoder_result_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with no request pending", '0, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_position !== want.position)
                  report_mismatch("position", want.position, rsp_position);
               if (rsp_direction !== want.direction)
                  report_mismatch("direction", want.direction, rsp_direction);
               if (rsp_interval_ms !== want.interval_ms)
                  report_mismatch("interval_ms", want.interval_ms, rsp_interval_ms);
               if (rsp_rpm !== want.rpm)
                  report_mismatch("rpm", want.rpm, rsp_rpm);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= qed_pkg::KIND_SAMPLE;
      req_pin_a <= 1'b0;
      req_pin_b <= 1'b0;
      req_now_ms <= '0;
      req_new_position <= '0;
      csr_we <= 1'b0;
      csr_index <= qed_pkg::CSR_LATCH_MODE;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_corners();

      clk_ms = 32'hFFFF_FF80;
      apply_settings(qed_pkg::LATCH_ON_3, 8'd3, 11'd20);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_0, 8'd0, 11'd1);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_BOTH, 8'd255, 11'd1024);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_BOTH, 8'd1, 11'd2047);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_3, 8'd0, 11'd0);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_0, 8'd7, 11'd3);
      test_random_rotation(60);
      apply_settings(LATCH_NEVER, 8'd2, 11'd100);
      test_random_rotation(60);
      apply_settings(qed_pkg::LATCH_ON_BOTH, 8'd4, 11'd1);
      test_random_rotation(60);

      test_receiver_holdoff();

      idle_on = 1'b0;
      apply_settings(qed_pkg::LATCH_ON_0, 8'd2, 11'd5);
      test_random_rotation(40);

      drain_requests();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
